/* design/lphash_pkg.sv */
// Shared constants, codes and control types of the linear probe hash table.
`default_nettype none

package lphash_pkg;

    localparam int KEY_BITS      = 31;
    localparam int KEY_TDATA_W   = 32;
    localparam int POS_W         = 10;
    localparam int POS_TDATA_W   = 16;
    localparam int STAT_W        = 2;
    localparam int CFG_W         = 11;
    localparam int DEPTH_DEFAULT = 1024;

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISS   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BADKEY = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_EVAL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clear;
        logic accept;
        logic mem_rd;
        logic eval;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic key_zero;
        logic div_done;
        logic eval_done;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

/* design/lphash_div.sv */
// Bit-serial restoring remainder unit: key mod table size, one bit per cycle.
`default_nettype none

module lphash_div import lphash_pkg::*; #(
    parameter int DIV_W = 11
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [KEY_BITS-1:0] dividend,
    input  wire logic [DIV_W-1:0]    divisor,
    output logic                     done,
    output logic [DIV_W-2:0]         rem
);

    localparam int REM_W = DIV_W - 1;
    localparam int CNT_W = $clog2(KEY_BITS);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [KEY_BITS-1:0] shift_reg;
    logic [DIV_W-1:0]    dsr_reg;
    logic [REM_W-1:0]    rem_reg;

    logic [DIV_W-1:0]    trial;
    logic [DIV_W-1:0]    diff;
    logic [REM_W-1:0]    rem_next;
    logic                last;

    always_comb begin
        trial    = {rem_reg, shift_reg[KEY_BITS-1]};
        diff     = trial - dsr_reg;
        rem_next = (trial >= dsr_reg) ? diff[REM_W-1:0] : trial[REM_W-1:0];
        last     = (cnt_reg == CNT_W'(KEY_BITS - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && last;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            shift_reg <= dividend;
            dsr_reg   <= divisor;
            rem_reg   <= '0;
        end else if (busy_reg) begin
            shift_reg <= {shift_reg[KEY_BITS-2:0], 1'b0};
            rem_reg   <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

/* design/lphash_dp.sv */
// Datapath: size register, slot memory, probe registers and output register.
`default_nettype none

module lphash_dp import lphash_pkg::*; #(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire cmd_t                   cmd,
    output sts_t                        sts,
    input  wire logic [KEY_TDATA_W-1:0] s_tdata,
    input  wire logic                   s_tuser,
    input  wire logic                   cfg_valid,
    input  wire logic [CFG_W-1:0]       cfg_data,
    input  wire logic                   m_tready,
    output logic                        m_tvalid,
    output logic [POS_TDATA_W-1:0]      m_tdata,
    output logic [STAT_W-1:0]           m_tuser
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int DIV_W = IDX_W + 1;
    localparam int MEM_W = KEY_BITS + 1;

    logic [MEM_W-1:0] mem [TABLE_DEPTH];

    logic [CFG_W-1:0]    size_cfg_reg;
    logic [IDX_W-1:0]    clr_reg;
    logic [IDX_W-1:0]    clr_next;
    logic                m_tvalid_reg;
    logic                m_tvalid_next;

    logic                func_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [DIV_W-1:0]    size_reg;
    logic [IDX_W-1:0]    slot_reg;
    logic [DIV_W-1:0]    cnt_reg;
    logic [MEM_W-1:0]    rd_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [STAT_W-1:0]   stat_reg;
    logic [POS_W-1:0]    m_pos_reg;
    logic [STAT_W-1:0]   m_stat_reg;

    logic [DIV_W-1:0]    used_size;
    logic [KEY_BITS-1:0] in_key;
    logic                key_zero;
    logic                div_done;
    logic [IDX_W-1:0]    div_rem;

    logic                rd_occ;
    logic                hit_free;
    logic                hit_key;
    logic [DIV_W-1:0]    cnt_inc;
    logic [DIV_W-1:0]    slot_inc;
    logic [IDX_W-1:0]    slot_wrap;
    logic                last_probe;
    logic                eval_done;
    logic [STAT_W-1:0]   eval_stat;
    logic                ins_wr;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [MEM_W-1:0]    mem_wdata;

    always_comb begin
        if (size_cfg_reg == '0) begin
            used_size = DIV_W'(1);
        end else if (32'(size_cfg_reg) > 32'(TABLE_DEPTH)) begin
            used_size = DIV_W'(TABLE_DEPTH);
        end else begin
            used_size = DIV_W'(32'(size_cfg_reg));
        end
    end

    assign in_key   = s_tdata[KEY_BITS-1:0];
    assign key_zero = (in_key == '0);

    lphash_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.accept && !key_zero),
        .dividend (in_key),
        .divisor  (used_size),
        .done     (div_done),
        .rem      (div_rem)
    );

    always_comb begin
        rd_occ     = rd_reg[KEY_BITS];
        hit_free   = !rd_occ;
        hit_key    = rd_occ && (rd_reg[KEY_BITS-1:0] == key_reg);
        cnt_inc    = cnt_reg + DIV_W'(1);
        last_probe = (cnt_inc == size_reg);
        slot_inc   = {1'b0, slot_reg} + DIV_W'(1);
        slot_wrap  = (slot_inc == size_reg) ? '0 : slot_inc[IDX_W-1:0];
        eval_done  = hit_free || ((func_reg == FUNC_SEARCH) && hit_key) || last_probe;
        if (hit_free) begin
            eval_stat = (func_reg == FUNC_INSERT) ? STAT_OK : STAT_MISS;
        end else if ((func_reg == FUNC_SEARCH) && hit_key) begin
            eval_stat = STAT_OK;
        end else begin
            eval_stat = (func_reg == FUNC_INSERT) ? STAT_FULL : STAT_MISS;
        end
        ins_wr = cmd.eval && (func_reg == FUNC_INSERT) && hit_free;
    end

    always_comb begin
        mem_we    = cmd.clear || ins_wr;
        mem_waddr = cmd.clear ? clr_reg : slot_reg;
        mem_wdata = cmd.clear ? '0 : {1'b1, key_reg};
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_rd) begin
            rd_reg <= mem[slot_reg];
        end
    end

    always_comb begin
        clr_next = cmd.clear ? clr_reg + IDX_W'(1) : clr_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_cfg_reg <= CFG_RESET;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                size_cfg_reg <= cfg_data;
            end
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            func_reg <= s_tuser;
            key_reg  <= in_key;
            size_reg <= used_size;
            pos_reg  <= '0;
            stat_reg <= STAT_BADKEY;
        end
        if (div_done) begin
            slot_reg <= div_rem;
            cnt_reg  <= '0;
        end
        if (cmd.eval) begin
            if (eval_done) begin
                stat_reg <= eval_stat;
                pos_reg  <= (eval_stat == STAT_OK) ? POS_W'(32'(slot_reg)) : '0;
            end else begin
                slot_reg <= slot_wrap;
                cnt_reg  <= cnt_inc;
            end
        end
        if (cmd.out_load) begin
            m_pos_reg  <= pos_reg;
            m_stat_reg <= stat_reg;
        end
    end

    always_comb begin
        sts.clr_last  = (clr_reg == IDX_W'(TABLE_DEPTH - 1));
        sts.key_zero  = key_zero;
        sts.div_done  = div_done;
        sts.eval_done = eval_done;
        sts.out_free  = !m_tvalid_reg || m_tready;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = POS_TDATA_W'(m_pos_reg);
    assign m_tuser  = m_stat_reg;

endmodule

`default_nettype wire

/* design/lphash_ctrl.sv */
// Controller: sequences clear pass, remainder, probe loop and result hand-off.
`default_nettype none

module lphash_ctrl import lphash_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = sts.key_zero ? ST_DONE : ST_DIV;
                end
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                state_next = sts.eval_done ? ST_DONE : ST_READ;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        cmd.clear    = (state_reg == ST_CLEAR);
        cmd.accept   = (state_reg == ST_IDLE) && s_tvalid;
        cmd.mem_rd   = (state_reg == ST_READ);
        cmd.eval     = (state_reg == ST_EVAL);
        cmd.out_load = (state_reg == ST_DONE) && sts.out_free;
        s_tready     = (state_reg == ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* design/linear_probe_hash_table_unit.sv */
// Top level of the linear probe hash table: controller, datapath and checks.
//
//  channel | direction | tdata                  | tuser
//  s_      | in        | [30:0] key             | [0] func (0 insert, 1 search)
//  m_      | out       | [9:0]  position        | [1:0] status
//  cfg_    | in        | [10:0] table_size      | -
//
//  An item passes through accept, the serial remainder unit (nonzero keys only),
//  a memory read and a compare per probe, and then the output register.
//  The registered slot memory read sets the probe cost.
//  After reset a clear pass writes every slot with s_tready low.
//  A stalled result holds in the output register; the next beat is accepted meanwhile.
`default_nettype none

module linear_probe_hash_table_unit import lphash_pkg::*; #(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [KEY_TDATA_W-1:0] s_tdata,   // [30:0] key
    input  wire logic                   s_tuser,   // [0] func
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [POS_TDATA_W-1:0]      m_tdata,   // [9:0] position
    output logic [STAT_W-1:0]           m_tuser,   // [1:0] status
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_W-1:0]       cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    lphash_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lphash_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice without finishing the item");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("output register loaded while holding an untaken beat");

    a_miss_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != STAT_OK) |-> (m_tdata == '0))
        else $error("nonzero position on a failed result");

    a_clear_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |-> !s_tready)
        else $error("input ready during the clear pass");

endmodule

`default_nettype wire
